/* src/tcgr_pkg.sv */
package tcgr_pkg;

    localparam int GLYPH_COLS = 8;
    localparam int ARITH_W    = 14;
    localparam int DIM_W      = 13;
    localparam int LINE_W     = 13;
    localparam int X_W        = 12;
    localparam int OFFSET_W   = 25;
    localparam int COLOR_W    = 32;
    localparam int FADDR_W    = 12;
    localparam int CODE_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0]        LEFT_BIT     = 8'h80;

    typedef enum logic [1:0] {
        OP_FONT_WRITE = 2'd0,
        OP_PRINT      = 2'd1,
        OP_HOME       = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_PITCH_WORDS   = 2'd2,
        REG_INK_COLOR     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DIM_W-1:0]   pitch;
        logic [COLOR_W-1:0] ink;
    } cfg_t;

    // One glyph row on its way from the sequencer to the output stages.
    typedef struct packed {
        logic               valid;
        logic [LINE_W-1:0]  col;
        logic [ARITH_W-1:0] y;
        logic               last;
        logic               glyph_ok;
    } row_req_t;

endpackage

/* src/text_console_glyph_renderer_unit.sv */
// Text console renderer with a 256-glyph 8x16 font store. A print beat for any
// character other than newline produces one output beat per glyph row, one row
// each cycle while the output takes beats, read from the single read port of
// the font memory, and the next input beat is taken in the cycle the last row
// is read. The first row passes the sequencer, font read and s1, s2 and output
// registers in turn; a stalled output holds the whole row pipeline. The font
// store has no reset and no clearing pass: load every glyph before printing it.
module text_console_glyph_renderer_unit #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcgr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcgr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcgr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_operation,
    input  logic [tcgr_pkg::CODE_W-1:0]      s_char_code,
    input  logic [tcgr_pkg::FADDR_W-1:0]     s_font_address,
    input  logic [tcgr_pkg::BYTE_W-1:0]      s_font_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcgr_pkg::X_W-1:0]         m_row_x,
    output logic [tcgr_pkg::LINE_W-1:0]      m_row_y,
    output logic [tcgr_pkg::OFFSET_W-1:0]    m_word_offset,
    output logic [7:0]                       m_pixel_mask,
    output logic [tcgr_pkg::COLOR_W-1:0]     m_pixel_color,
    output logic                             m_last_row
);
    import tcgr_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT * GLYPH_ROWS);

    cfg_t              cfg;
    row_req_t          req;
    logic              adv;
    logic              wr_en;
    logic [FADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    tcgr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcgr_row_seq #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .COORD_BITS  (COORD_BITS),
        .AW          (AW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .adv            (adv),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_char_code    (s_char_code),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .req            (req)
    );

    tcgr_glyph_mem #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS),
        .AW          (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcgr_row_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .req           (req),
        .rd_data       (rd_data),
        .adv           (adv),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_x       (m_row_x),
        .m_row_y       (m_row_y),
        .m_word_offset (m_word_offset),
        .m_pixel_mask  (m_pixel_mask),
        .m_pixel_color (m_pixel_color),
        .m_last_row    (m_last_row)
    );

endmodule

/* src/tcgr_regs.sv */
module tcgr_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcgr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcgr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcgr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output tcgr_pkg::cfg_t                   cfg
);
    import tcgr_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= 13'd640;
            cfg_reg.height <= 13'd480;
            cfg_reg.pitch  <= 13'd640;
            cfg_reg.ink    <= 32'h00FF_FFFF;
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_SCREEN_WIDTH:  cfg_reg.width  <= pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.height <= pwdata[DIM_W-1:0];
                REG_PITCH_WORDS:   cfg_reg.pitch  <= pwdata[DIM_W-1:0];
                REG_INK_COLOR:     cfg_reg.ink    <= pwdata[COLOR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(cfg_reg.width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(cfg_reg.height);
            REG_PITCH_WORDS:   prdata = APB_DATA_W'(cfg_reg.pitch);
            REG_INK_COLOR:     prdata = APB_DATA_W'(cfg_reg.ink);
        endcase
    end

endmodule

/* src/tcgr_glyph_mem.sv */
module tcgr_glyph_mem #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16,
    parameter int AW          = $clog2(GLYPH_COUNT * GLYPH_ROWS)
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [tcgr_pkg::FADDR_W-1:0]   wr_addr,
    input  logic [tcgr_pkg::BYTE_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr,
    output logic [tcgr_pkg::BYTE_W-1:0]    rd_data
);
    import tcgr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;

    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [ARITH_W-1:0] wa;

    assign wa      = ARITH_W'(wr_addr);
    assign rd_data = rd_data_reg;

    // Addresses past the end of the store are dropped.
    always_ff @(posedge aclk) begin
        if (wr_en && (wa < ARITH_W'(DEPTH))) begin
            mem[wa[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* src/tcgr_row_seq.sv */
module tcgr_row_seq #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_ROWS  = 16,
    parameter int COORD_BITS  = 12,
    parameter int AW          = $clog2(GLYPH_COUNT * GLYPH_ROWS)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tcgr_pkg::cfg_t                 cfg,
    input  logic                           adv,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [tcgr_pkg::CODE_W-1:0]    s_char_code,
    input  logic [tcgr_pkg::FADDR_W-1:0]   s_font_address,
    input  logic [tcgr_pkg::BYTE_W-1:0]    s_font_byte,
    output logic                           wr_en,
    output logic [tcgr_pkg::FADDR_W-1:0]   wr_addr,
    output logic [tcgr_pkg::BYTE_W-1:0]    wr_data,
    output logic [AW-1:0]                  rd_addr,
    output tcgr_pkg::row_req_t             req
);
    import tcgr_pkg::*;

    localparam int              ROW_W    = $clog2(GLYPH_ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

    logic [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic [LINE_W-1:0]     cur_line_reg, cur_line_next;
    logic                  busy_reg, busy_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [LINE_W-1:0]     line_reg, line_next;
    logic [CODE_W-1:0]     code_reg, code_next;

    logic                  accept;
    logic                  wrap_x;
    logic [ARITH_W-1:0]    col_a, line_a, line_b;
    logic [ARITH_W-1:0]    addr_w;

    assign accept = s_valid && s_ready;
    assign s_ready = adv && (!busy_reg || (row_reg == LAST_ROW));

    // Right edge wrap first, then bottom edge wrap on the result.
    always_comb begin
        wrap_x = (ARITH_W'(cur_col_reg) + ARITH_W'(GLYPH_COLS)) >= ARITH_W'(cfg.width);
        col_a  = wrap_x ? '0 : ARITH_W'(cur_col_reg);
        line_a = wrap_x ? ARITH_W'(cur_line_reg) + ARITH_W'(GLYPH_ROWS)
                        : ARITH_W'(cur_line_reg);
        line_b = ((line_a + ARITH_W'(GLYPH_ROWS)) >= ARITH_W'(cfg.height)) ? '0 : line_a;
    end

    assign wr_en   = accept && (s_operation == OP_FONT_WRITE);
    assign wr_addr = s_font_address;
    assign wr_data = s_font_byte;

    always_comb begin
        cur_col_next  = cur_col_reg;
        cur_line_next = cur_line_reg;
        busy_next     = busy_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        line_next     = line_reg;
        code_next     = code_reg;
        if (adv && busy_reg) begin
            if (row_reg == LAST_ROW) begin
                busy_next = 1'b0;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
        if (accept) begin
            unique case (s_operation)
                OP_PRINT: begin
                    if (s_char_code == NEWLINE_CODE) begin
                        cur_col_next  = '0;
                        cur_line_next = LINE_W'(line_b + ARITH_W'(GLYPH_ROWS));
                    end else begin
                        cur_col_next  = COORD_BITS'(col_a + ARITH_W'(GLYPH_COLS));
                        cur_line_next = line_b[LINE_W-1:0];
                        busy_next     = 1'b1;
                        row_next      = '0;
                        col_next      = col_a[COORD_BITS-1:0];
                        line_next     = line_b[LINE_W-1:0];
                        code_next     = s_char_code;
                    end
                end
                OP_HOME: begin
                    cur_col_next  = '0;
                    cur_line_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg  <= '0;
            cur_line_reg <= '0;
            busy_reg     <= 1'b0;
            row_reg      <= '0;
        end else begin
            cur_col_reg  <= cur_col_next;
            cur_line_reg <= cur_line_next;
            busy_reg     <= busy_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg  <= col_next;
        line_reg <= line_next;
        code_reg <= code_next;
    end

    assign addr_w = ARITH_W'(code_reg) * ARITH_W'(GLYPH_ROWS) + ARITH_W'(row_reg);
    assign rd_addr = addr_w[AW-1:0];

    always_comb begin
        req.valid    = busy_reg;
        req.col      = LINE_W'(col_reg);
        req.y        = ARITH_W'(line_reg) + ARITH_W'(row_reg);
        req.last     = (row_reg == LAST_ROW);
        req.glyph_ok = ({1'b0, code_reg} < (CODE_W + 1)'(GLYPH_COUNT));
    end

    a_new_char_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_operation == OP_PRINT) && (s_char_code != NEWLINE_CODE)
        |=> busy_reg && (row_reg == '0))
        else $error("printed character did not start at row zero");

    a_no_accept_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (row_reg != LAST_ROW) |-> !s_ready)
        else $error("input taken while glyph rows remain to be read");

    a_char_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && adv && (row_reg == LAST_ROW) && !accept |=> !busy_reg)
        else $error("sequencer kept running past the last row");

endmodule

/* src/tcgr_row_out.sv */
module tcgr_row_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tcgr_pkg::cfg_t                   cfg,
    input  tcgr_pkg::row_req_t               req,
    input  logic [tcgr_pkg::BYTE_W-1:0]      rd_data,
    output logic                             adv,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcgr_pkg::X_W-1:0]         m_row_x,
    output logic [tcgr_pkg::LINE_W-1:0]      m_row_y,
    output logic [tcgr_pkg::OFFSET_W-1:0]    m_word_offset,
    output logic [7:0]                       m_pixel_mask,
    output logic [tcgr_pkg::COLOR_W-1:0]     m_pixel_color,
    output logic                             m_last_row
);
    import tcgr_pkg::*;

    row_req_t              s1_reg;
    logic                  s2_valid_reg;
    logic [OFFSET_W-1:0]   s2_prod_reg;
    logic [7:0]            s2_mask_reg;
    logic [LINE_W-1:0]     s2_col_reg;
    logic [LINE_W-1:0]     s2_y_reg;
    logic                  s2_last_reg;
    logic                  m_valid_reg;
    logic [X_W-1:0]        m_row_x_reg;
    logic [LINE_W-1:0]     m_row_y_reg;
    logic [OFFSET_W-1:0]   m_word_offset_reg;
    logic [7:0]            m_pixel_mask_reg;
    logic [COLOR_W-1:0]    m_pixel_color_reg;
    logic                  m_last_row_reg;

    logic [7:0]            bits;
    logic [7:0]            mask_next;

    // The whole row pipeline moves together whenever the output can take a beat.
    assign adv = !m_valid_reg || m_ready;

    always_comb begin
        bits      = s1_reg.glyph_ok ? rd_data : '0;
        mask_next = '0;
        if (s1_reg.y < ARITH_W'(cfg.height)) begin
            for (int c = 0; c < GLYPH_COLS; c++) begin
                if ((bits & (LEFT_BIT >> c)) != '0 &&
                    (ARITH_W'(s1_reg.col) + ARITH_W'(c)) < ARITH_W'(cfg.width)) begin
                    mask_next = mask_next | (LEFT_BIT >> c);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_reg.valid <= req.valid;
            s2_valid_reg <= s1_reg.valid;
            m_valid_reg  <= s2_valid_reg;

            s1_reg.col      <= req.col;
            s1_reg.y        <= req.y;
            s1_reg.last     <= req.last;
            s1_reg.glyph_ok <= req.glyph_ok;

            s2_prod_reg <= OFFSET_W'(s1_reg.y[LINE_W-1:0]) * OFFSET_W'(cfg.pitch);
            s2_mask_reg <= mask_next;
            s2_col_reg  <= s1_reg.col;
            s2_y_reg    <= s1_reg.y[LINE_W-1:0];
            s2_last_reg <= s1_reg.last;

            m_row_x_reg       <= s2_col_reg[X_W-1:0];
            m_row_y_reg       <= s2_y_reg;
            m_word_offset_reg <= s2_prod_reg + OFFSET_W'(s2_col_reg);
            m_pixel_mask_reg  <= s2_mask_reg;
            m_pixel_color_reg <= cfg.ink;
            m_last_row_reg    <= s2_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row_x       = m_row_x_reg;
    assign m_row_y       = m_row_y_reg;
    assign m_word_offset = m_word_offset_reg;
    assign m_pixel_mask  = m_pixel_mask_reg;
    assign m_pixel_color = m_pixel_color_reg;
    assign m_last_row    = m_last_row_reg;

endmodule

/* test/text_console_glyph_renderer_unit_tb.sv */
`timescale 1ns / 100ps

module text_console_glyph_renderer_unit_tb;

    import tcgr_pkg::*;

    localparam int          GLYPH_ROWS   = 16;
    localparam int          STORE_DEPTH  = 256 * GLYPH_ROWS;
    localparam logic [1:0]  OP_IGNORED   = 2'd3;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE_TICKS = 12;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_PHASES = 5;
    localparam int          BEATS_PER_PHASE = 50;

    typedef struct packed {
        logic [X_W-1:0]      x;
        logic [LINE_W-1:0]   y;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          mask;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } glyph_row_t;

    // Tracks the cursor, font store and screen settings, and queues the row beats that
    // each accepted character is going to produce.
    class console_raster_model;
        int unsigned  width, height, pitch;
        logic [31:0]  ink;
        int unsigned  cur_col, cur_line;
        logic [7:0]   font [STORE_DEPTH];
        bit           loaded [STORE_DEPTH];
        glyph_row_t   pending_rows [$];
        int           mismatches, rows_checked, chars_drawn, font_bytes, settings;

        function new();
            width    = 640;
            height   = 480;
            pitch    = 640;
            ink      = 32'h00FF_FFFF;
            cur_col  = 0;
            cur_line = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_SCREEN_WIDTH:  width  = 32'(value[DIM_W-1:0]);
                REG_SCREEN_HEIGHT: height = 32'(value[DIM_W-1:0]);
                REG_PITCH_WORDS:   pitch  = 32'(value[DIM_W-1:0]);
                REG_INK_COLOR:     ink    = value;
                default: ;
            endcase
        endfunction

        function void render_glyph(logic [7:0] code);
            int unsigned col, line, y;
            logic [7:0]  bits, mask;
            bit [63:0]   product;
            glyph_row_t  row;
            col  = cur_col;
            line = cur_line;
            // Right edge first, then bottom edge; each is checked once per character.
            if (col + GLYPH_COLS >= width) begin
                col  = 0;
                line = line + GLYPH_ROWS;
            end
            if (line + GLYPH_ROWS >= height)
                line = 0;
            if (code == NEWLINE_CODE) begin
                cur_col  = 0;
                cur_line = (line + GLYPH_ROWS) & 32'h1FFF;
                return;
            end
            col  = col & 32'hFFF;
            line = line & 32'h1FFF;
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                y    = line + r;
                bits = font[code * GLYPH_ROWS + r];
                mask = 8'h00;
                if (y < height) begin
                    for (int c = 0; c < GLYPH_COLS; c++) begin
                        if ((bits & (LEFT_BIT >> c)) != 0 && col + c < width)
                            mask = mask | (LEFT_BIT >> c);
                    end
                end
                product    = 64'(y & 32'h1FFF) * 64'(pitch) + 64'(col);
                row.x      = col[X_W-1:0];
                row.y      = y[LINE_W-1:0];
                row.offset = product[OFFSET_W-1:0];
                row.mask   = mask;
                row.color  = ink;
                row.last   = (r == GLYPH_ROWS - 1);
                pending_rows.push_back(row);
            end
            cur_col  = (col + GLYPH_COLS) & 32'hFFF;
            cur_line = line;
            chars_drawn++;
        endfunction

        function void take_beat(logic [1:0] op, logic [7:0] code, logic [11:0] addr,
                                logic [7:0] data);
            case (op)
                OP_FONT_WRITE: begin
                    font[addr]   = data;
                    loaded[addr] = 1'b1;
                    font_bytes++;
                end
                OP_PRINT: render_glyph(code);
                OP_HOME: begin
                    cur_col  = 0;
                    cur_line = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_row(glyph_row_t got);
            glyph_row_t want;
            rows_checked++;
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row beat: x=%0d y=%0d off=%0d ",
                             got.x, got.y, got.offset,
                             "mask=%02h color=%08h last=%0b",
                             got.mask, got.color, got.last);
                return;
            end
            want = pending_rows.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.offset !== want.offset ||
                got.mask !== want.mask || got.color !== want.color ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row mismatch: want x=%0d y=%0d off=%0d ",
                             want.x, want.y, want.offset,
                             "mask=%02h color=%08h last=%0b, ",
                             want.mask, want.color, want.last,
                             "got x=%0d y=%0d off=%0d ",
                             got.x, got.y, got.offset,
                             "mask=%02h color=%08h last=%0b",
                             got.mask, got.color, got.last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel, penable, pwrite, pready;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;
    logic                  s_valid, s_ready;
    logic [1:0]            s_operation;
    logic [CODE_W-1:0]     s_char_code;
    logic [FADDR_W-1:0]    s_font_address;
    logic [BYTE_W-1:0]     s_font_byte;
    logic                  m_valid, m_ready;
    logic [X_W-1:0]        m_row_x;
    logic [LINE_W-1:0]     m_row_y;
    logic [OFFSET_W-1:0]   m_word_offset;
    logic [7:0]            m_pixel_mask;
    logic [COLOR_W-1:0]    m_pixel_color;
    logic                  m_last_row;

    console_raster_model raster = new();
    bit          burst_mode  = 1'b0;
    bit          hold_wanted = 1'b0;
    int          cycle_count = 0;
    int          beats_sent  = 0;
    logic [7:0]  ready_codes [$];
    logic [7:0]  loading_code;
    int          loading_row;

    text_console_glyph_renderer_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_char_code    (s_char_code),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_x        (m_row_x),
        .m_row_y        (m_row_y),
        .m_word_offset  (m_word_offset),
        .m_pixel_mask   (m_pixel_mask),
        .m_pixel_color  (m_pixel_color),
        .m_last_row     (m_last_row)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] op, logic [7:0] code, logic [11:0] addr,
                             logic [7:0] data);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_char_code    <= code;
        s_font_address <= addr;
        s_font_byte    <= data;
        do @(posedge aclk); while (!s_ready);
        raster.take_beat(op, code, addr, data);
        beats_sent++;
    endtask

    task automatic send_print(logic [7:0] code);
        send_beat(OP_PRINT, code, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    endtask

    // Registers may only change while nothing is in flight, so let the rows drain first.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (raster.pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        raster.set_register(idx, value);
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [31:0] w, logic [31:0] h, logic [31:0] p,
                                  logic [31:0] color);
        settle_block();
        apb_write(REG_SCREEN_WIDTH, w);
        apb_write(REG_SCREEN_HEIGHT, h);
        apb_write(REG_PITCH_WORDS, p);
        apb_write(REG_INK_COLOR, color);
        raster.settings++;
    endtask

    task automatic pick_random_settings();
        logic [31:0] w, h, p;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(1, 12);
            1: w = $urandom_range(13, 96);
            2: w = $urandom_range(97, 4096);
            default: w = 4096;
        endcase
        if ($urandom_range(0, 2) != 0)
            h = $urandom_range(1, 80);
        else
            h = $urandom_range(81, 4096);
        p = $urandom_range(1, 4096);
        apply_settings(w, h, p, $urandom);
    endtask

    // Mostly whole glyph loads followed by prints of loaded glyphs; the rest is stray
    // font writes, homes and unused operations.
    task automatic random_beat();
        int         pick;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 24) begin
            send_beat(OP_FONT_WRITE, 8'($urandom_range(0, 255)),
                      {loading_code, loading_row[3:0]}, 8'($urandom_range(0, 255)));
            loading_row++;
            if (loading_row == GLYPH_ROWS) begin
                ready_codes.push_back(loading_code);
                loading_code = 8'($urandom_range(0, 255));
                loading_row  = 0;
            end
        end else if (pick < 30) begin
            send_beat(OP_FONT_WRITE, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
            if ($urandom_range(0, 9) == 0)
                code = NEWLINE_CODE;
            else
                code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
            send_print(code);
        end else if (pick < 93) begin
            send_beat(OP_HOME, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)));
        end else begin
            send_beat(OP_IGNORED, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                      8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : row_sink
        int         stall;
        glyph_row_t got;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_wanted) begin
                stall       = HOLD_CYCLES;
                hold_wanted = 1'b0;
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.x      = m_row_x;
            got.y      = m_row_y;
            got.offset = m_word_offset;
            got.mask   = m_pixel_mask;
            got.color  = m_pixel_color;
            got.last   = m_last_row;
            raster.check_row(got);
        end
    end

    initial begin : stimulus
        logic [7:0] edge_rows [4];
        edge_rows = '{8'hFF, 8'h00, 8'h80, 8'h01};
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_operation    <= OP_HOME;
        s_char_code    <= '0;
        s_font_address <= '0;
        s_font_byte    <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset settings: glyph 0 with extreme row patterns.
        for (int r = 0; r < GLYPH_ROWS; r++)
            send_beat(OP_FONT_WRITE, 8'($urandom_range(0, 255)), 12'(r),
                      (r < 4) ? edge_rows[r] : 8'($urandom_range(0, 255)));
        ready_codes.push_back(8'd0);
        send_beat(OP_FONT_WRITE, 8'($urandom_range(0, 255)), 12'hFFF, 8'hFF);
        send_print(8'd0);
        send_print(8'd0);
        send_print(NEWLINE_CODE);
        send_print(8'd0);
        send_beat(OP_IGNORED, 8'hFF, 12'hFFF, 8'hFF);
        send_beat(OP_HOME, 8'hFF, 12'hFFF, 8'hFF);
        send_print(8'd0);

        apply_settings(4096, 4096, 4096, 32'hFFFF_FFFF);
        send_print(8'd0);
        send_print(NEWLINE_CODE);
        send_print(8'd0);

        // A one-pixel screen: every glyph wraps to the origin and clips to one pixel.
        apply_settings(1, 1, 1, 32'h0);
        send_print(8'd0);
        send_print(8'd0);

        // With no visible area every row comes out fully masked.
        apply_settings(0, 0, 4096, 32'h5A5A_A5A5);
        send_print(8'd0);
        send_print(NEWLINE_CODE);
        send_print(8'd0);

        loading_code = 8'd255;
        loading_row  = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_random_settings();
            burst_mode = (phase % 2 == 1);
            if (phase == 2)
                hold_wanted = 1'b1;
            repeat (BEATS_PER_PHASE) random_beat();
        end
        burst_mode = 1'b0;
        settle_block();

        $display("Run covered %0d input beats: %0d characters drawn, %0d font bytes loaded,",
                 beats_sent, raster.chars_drawn, raster.font_bytes);
        $display("%0d row beats checked over %0d register settings, %0d mismatches.",
                 raster.rows_checked, raster.settings + 1, raster.mismatches);
        if (raster.pending_rows.size() != 0)
            $display("%0d expected row beats never arrived", raster.pending_rows.size());
        if (raster.mismatches == 0 && raster.pending_rows.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
